FILE: design/dsfp_pkg.sv
// Shared types, constants and codes for the distance sensor frame parser.
package dsfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned POS_W    = 2;

  localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'hFF;

  localparam logic [DIST_W-1:0] MIN_DIST_RESET = 16'd30;
  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 16'd4500;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd1;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd2;

  localparam logic [POS_W-1:0] POS_HUNT  = 2'd0;
  localparam logic [POS_W-1:0] POS_HIGH  = 2'd1;
  localparam logic [POS_W-1:0] POS_LOW   = 2'd2;
  localparam logic [POS_W-1:0] POS_CHECK = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance_tenth_cm;
  } dsfp_word_t;

  typedef struct packed {
    logic       valid;
    dsfp_word_t word;
  } dsfp_result_t;

endpackage

FILE: design/dsfp_if.sv
// Valid/ready channel interfaces for the received byte input and the distance result output.
interface dsfp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface dsfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] distance_tenth_cm;

  modport source (output valid, output status, output distance_tenth_cm, input ready);
  modport sink   (input valid, input status, input distance_tenth_cm, output ready);
endinterface

FILE: design/dsfp_parser.sv
// Frame assembly state machine with checksum and range check for one accepted word.
module dsfp_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic                          op,
  input  logic [dsfp_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [dsfp_pkg::DIST_W-1:0]   min_dist,
  input  logic [dsfp_pkg::DIST_W-1:0]   max_dist,
  output dsfp_pkg::dsfp_result_t        res
);
  import dsfp_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] high_r, high_nxt;
  logic [BYTE_W-1:0] low_r, low_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [DIST_W-1:0] dist_mm;

  assign dist_mm = {high_r, low_r};

  always_comb begin
    pos_nxt  = pos_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    sum_nxt  = sum_r;
    res      = '0;
    if (fire) begin
      if (op == OP_TIMEOUT) begin
        pos_nxt  = POS_HUNT;
        high_nxt = '0;
        low_nxt  = '0;
        sum_nxt  = '0;
        res.valid = 1'b1;
        res.word.status = STATUS_TIMEOUT;
        res.word.distance_tenth_cm = '0;
      end else begin
        case (pos_r)
          POS_HUNT: begin
            if (rx_byte == FRAME_HEADER) begin
              sum_nxt = FRAME_HEADER;
              pos_nxt = POS_HIGH;
            end
          end
          POS_HIGH: begin
            high_nxt = rx_byte;
            sum_nxt  = sum_r + rx_byte;
            pos_nxt  = POS_LOW;
          end
          POS_LOW: begin
            low_nxt = rx_byte;
            sum_nxt = sum_r + rx_byte;
            pos_nxt = POS_CHECK;
          end
          default: begin
            pos_nxt = POS_HUNT;
            if (rx_byte == sum_r) begin
              res.valid = 1'b1;
              res.word.distance_tenth_cm = dist_mm;
              if ((dist_mm < min_dist) || (dist_mm > max_dist)) begin
                res.word.status = STATUS_RANGE;
              end else begin
                res.word.status = STATUS_OK;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HUNT;
      high_r <= '0;
      low_r  <= '0;
      sum_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      sum_r  <= sum_nxt;
    end
  end

  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op == OP_TIMEOUT) |=> (pos_r == POS_HUNT) && (sum_r == '0))
    else $error("timeout did not clear the parser");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> fire && ((op == OP_TIMEOUT) || (pos_r == POS_CHECK)))
    else $error("result raised outside a checksum or timeout word");

  a_hunt_drops: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op == OP_BYTE) && (pos_r == POS_HUNT) && (rx_byte != FRAME_HEADER)
      |=> pos_r == POS_HUNT)
    else $error("non-header word left the hunting state");

endmodule

FILE: design/distance_sensor_frame_parser_core.sv
// Top level of the distance sensor frame parser: configuration, parser and output buffering.
//
// The in_ch channel carries one word per handshake: a received byte (op 0) or a
// read timeout event (op 1). The out_ch channel returns a status and a distance
// in millimetres for every good frame and for every timeout; other words give
// no result. The configuration port writes the minimum (index 0) and maximum
// (index 1) distance; other indexes are ignored.
// A result goes to the output register, or to the skid register while the
// output register holds an untaken result. One word is accepted per cycle while
// in_ch.ready is high, a figure set by the single parser state update per word.
// The output register is backed by a one-entry skid register, so words keep
// being accepted while a result waits. in_ch.ready drops only when both hold a
// result, and rises again as soon as the receiver takes one.
// Reset clears the parser to hunting for a header, empties both output
// registers and loads the distance bounds with 30 mm and 4500 mm.
module distance_sensor_frame_parser_core (
  input  logic                              clk,
  input  logic                              rst_n,
  dsfp_in_if.sink                           in_ch,
  dsfp_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [dsfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsfp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dsfp_pkg::*;

  logic [DIST_W-1:0] min_dist_r;
  logic [DIST_W-1:0] max_dist_r;
  logic              out_valid_r;
  dsfp_word_t        out_word_r;
  logic              skid_valid_r;
  dsfp_word_t        skid_word_r;
  logic              in_fire;
  logic              out_take;
  dsfp_result_t      res;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_take    = out_valid_r && out_ch.ready;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_word_r.status;
  assign out_ch.distance_tenth_cm = out_word_r.distance_tenth_cm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RESET;
      max_dist_r <= MAX_DIST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_DIST: min_dist_r <= cfg_wdata[DIST_W-1:0];
        CFG_MAX_DIST: max_dist_r <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  dsfp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .op       (in_ch.op),
    .rx_byte  (in_ch.rx_byte),
    .min_dist (min_dist_r),
    .max_dist (max_dist_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_word_r   <= skid_word_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid_r || out_take) begin
        out_word_r  <= res.word;
        out_valid_r <= 1'b1;
      end else begin
        skid_word_r  <= res.word;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && res.valid |=> skid_valid_r)
    else $error("result lost while the receiver stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ch.ready |=> !skid_valid_r && out_valid_r)
    else $error("skid register did not drain into the output register");

endmodule
